// ----- sv/lmo_pkg.sv -----
`timescale 1ns / 1ps
package lmo_pkg;

  localparam int SEQ_MAX   = 1024;
  localparam int SEQ_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int OTU_W     = 11;
  localparam int SIM_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [OTU_W-1:0] OTU_NONE = '1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SAME  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OTU   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL       = 2'd2;

  typedef struct packed {
    logic             op;
    logic [SEQ_W-1:0] seq_a;
    logic [SEQ_W-1:0] seq_b;
    logic [SIM_W-1:0] similarity;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SEQ_W-1:0] kept_root;
    logic [SEQ_W-1:0] absorbed_root;
    logic [OTU_W-1:0] otu_total;
    logic [SEQ_W-1:0] root_of_seq;
    logic [SEQ_W-1:0] otu_of_seq;
    logic             otu_valid;
    logic [SIM_W-1:0] otu_similarity;
  } out_rsp_t;

  // one entry of the sequence memory
  typedef struct packed {
    logic [SEQ_W-1:0]  label;
    logic [SIZE_W-1:0] size;
    logic [OTU_W-1:0]  otu;
  } entry_t;

  function automatic logic otu_ok(input logic [OTU_W-1:0] id);
    return id < OTU_W'(SEQ_MAX);
  endfunction

  // signed level - similarity below tolerance
  function automatic logic tol_hit(input logic [SIM_W-1:0] level,
                                   input logic [SIM_W-1:0] sim,
                                   input logic [SIM_W-1:0] tol);
    logic signed [SIM_W+1:0] diff;
    diff = $signed({2'b00, level}) - $signed({2'b00, sim});
    return diff < $signed({2'b00, tol});
  endfunction

endpackage

// ----- sv/lmo_ram.sv -----
`timescale 1ns / 1ps
module lmo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/linkage_merge_otu_assigner.sv -----
`timescale 1ns / 1ps
// Single-linkage cluster merger with OTU assignment.
// Input channel (in_valid/in_ready/in_data): one request per item, either a
// merge of seq_a and seq_b at a similarity, or a query of seq_a.
// Result channel (out_valid/out_ready/out_data): exactly one result per request,
// held in an output register until taken.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no request is in flight.
// A rejected request goes straight to its result; a query reads its entry, and
// then the OTU level when the sequence has one; a merge within one cluster ends
// once both labels are read. A merge of two clusters makes one sweep through the
// sequence memory, one entry read and written back per cycle, which relabels,
// assigns OTUs and sums sizes in one pass.
// Throughput: one request at a time; in_ready returns as the result is loaded,
// together with out_valid.
// Reset: after rst_n rises a clearing pass over all SEQ_MAX entries initialises the
// sequence memory (label = index, size 1, no OTU); in_ready stays low till then.
// The OTU level memory is not cleared; only created OTU ids are read.
// Stall: while a result waits, the next request may be accepted and worked on;
// its result is held back until the output register frees.
module linkage_merge_otu_assigner (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lmo_pkg::in_req_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lmo_pkg::out_rsp_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [lmo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmo_pkg::CFG_W-1:0]     cfg_data
);
  import lmo_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_Q_A, S_Q_L, S_M_A, S_M_B, S_M_X, S_M_Y,
    S_M_DEC, S_M_NEW, S_M_JY, S_M_JX, S_SCAN, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [SIZE_W-1:0] seq_count_r, min_otu_r;
  logic [SIM_W-1:0]  tol_r;

  // request context
  in_req_t           req_r;
  out_rsp_t          rsp_r, out_r;
  logic              out_valid_r;
  logic [OTU_W-1:0]  cnt_r;
  logic [SEQ_W-1:0]  clr_i_r;
  logic [SEQ_W-1:0]  lab_a_r, x_r, y_r;
  logic [OTU_W-1:0]  otu_a_r, otu_dx_r, otu_dy_r, otu_x_r, otu_y_r;
  logic [SIZE_W-1:0] size_x_r, size_y_r;
  logic [OTU_W-1:0]  tgt_x_r, tgt_y_r, eff_dy_r, eff_y_r;
  logic              set_x_r, set_y_r;
  logic [SIZE_W-1:0] scan_rd_r;
  logic              wb_v_r;
  logic [SEQ_W-1:0]  wb_addr_r;

  // memories
  logic              em_we, em_re;
  logic [SEQ_W-1:0]  em_waddr, em_raddr;
  entry_t            em_wdata, em_rdata;
  logic              lv_we, lv_re;
  logic [SEQ_W-1:0]  lv_waddr, lv_raddr;
  logic [SIM_W-1:0]  lv_rdata;

  lmo_ram #(.WIDTH($bits(entry_t)), .DEPTH(SEQ_MAX)) u_entry_ram (
    .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
    .re(em_re), .raddr(em_raddr), .rdata(em_rdata)
  );

  lmo_ram #(.WIDTH(SIM_W), .DEPTH(SEQ_MAX)) u_level_ram (
    .clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(req_r.similarity),
    .re(lv_re), .raddr(lv_raddr), .rdata(lv_rdata)
  );

  logic in_acc, in_bad, big, new_x, new_y;
  logic hit_y, app_y, hit_x, app_x;
  logic [OTU_W-1:0] id_y, id_x, eff_dy, eff_y;
  logic [SEQ_W-1:0] lo_root, hi_root;
  entry_t wb_ent;
  out_rsp_t fin_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    in_bad = ({1'b0, in_data.seq_a} >= seq_count_r) ||
             (!in_data.op && ({1'b0, in_data.seq_b} >= seq_count_r));
    lo_root = (lab_a_r > em_rdata.label) ? em_rdata.label : lab_a_r;
    hi_root = (lab_a_r > em_rdata.label) ? lab_a_r : em_rdata.label;
    big   = (size_x_r >= min_otu_r) && (size_y_r >= min_otu_r);
    new_x = (otu_x_r == OTU_NONE) && (cnt_r < OTU_W'(SEQ_MAX));
    new_y = (otu_y_r == OTU_NONE) && (cnt_r < OTU_W'(SEQ_MAX));
    // small absorbed cluster: partner's OTU if close enough, else the survivor's
    hit_y  = otu_ok(otu_dx_r) && tol_hit(lv_rdata, req_r.similarity, tol_r);
    id_y   = hit_y ? otu_dx_r : otu_x_r;
    app_y  = (size_y_r < min_otu_r) && otu_ok(id_y);
    eff_dy = app_y ? id_y : otu_dy_r;
    eff_y  = app_y ? id_y : otu_y_r;
    // small surviving cluster sees the state left by the step above
    hit_x  = otu_ok(eff_dy_r) && tol_hit(lv_rdata, req_r.similarity, tol_r);
    id_x   = hit_x ? eff_dy_r : eff_y_r;
    app_x  = (size_x_r < min_otu_r) && otu_ok(id_x);
    // result as loaded into the output register, with the current OTU count
    fin_rsp           = rsp_r;
    fin_rsp.otu_total = cnt_r;
  end

  // write-back of one swept entry
  always_comb begin
    wb_ent = em_rdata;
    if (em_rdata.label == x_r) begin
      if (set_x_r) wb_ent.otu = tgt_x_r;
      if (wb_addr_r == x_r) wb_ent.size = size_x_r + size_y_r;
    end else if (em_rdata.label == y_r) begin
      wb_ent.label = x_r;
      if (set_y_r) wb_ent.otu = tgt_y_r;
      if (wb_addr_r == y_r) wb_ent.size = '0;
    end
  end

  always_comb begin
    em_we    = 1'b0;
    em_waddr = wb_addr_r;
    em_wdata = wb_ent;
    em_re    = 1'b0;
    em_raddr = in_data.seq_a;
    lv_we    = 1'b0;
    lv_waddr = cnt_r[SEQ_W-1:0];
    lv_re    = 1'b0;
    lv_raddr = otu_dx_r[SEQ_W-1:0];
    case (state_r)
      S_CLEAR: begin
        em_we    = 1'b1;
        em_waddr = clr_i_r;
        em_wdata = '{label: clr_i_r, size: SIZE_W'(1), otu: OTU_NONE};
      end
      S_IDLE: em_re = in_acc;
      S_Q_A: begin
        lv_re    = 1'b1;
        lv_raddr = em_rdata.otu[SEQ_W-1:0];
      end
      S_M_A: begin
        em_re    = 1'b1;
        em_raddr = req_r.seq_b;
      end
      S_M_B: begin
        em_re    = 1'b1;
        em_raddr = lo_root;
      end
      S_M_X: begin
        em_re    = 1'b1;
        em_raddr = y_r;
      end
      S_M_DEC: begin
        lv_we = big && new_x;
        lv_re = !big;
      end
      S_M_NEW: lv_we = new_y;
      S_M_JY: begin
        lv_re    = 1'b1;
        lv_raddr = eff_dy[SEQ_W-1:0];
      end
      S_SCAN: begin
        em_re    = (scan_rd_r < SIZE_W'(SEQ_MAX));
        em_raddr = scan_rd_r[SEQ_W-1:0];
        em_we    = wb_v_r;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_count_r <= SIZE_W'(SEQ_MAX);
      min_otu_r   <= SIZE_W'(50);
      tol_r       <= SIM_W'(1638);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEQ_COUNT: seq_count_r <= cfg_data[SIZE_W-1:0];
        CFG_MIN_OTU:   min_otu_r   <= cfg_data[SIZE_W-1:0];
        CFG_TOL:       tol_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_i_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wb_v_r      <= 1'b0;
    end else begin
      // drop the taken result; the finish state reloads it itself
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_i_r <= clr_i_r + 1'b1;
          if (clr_i_r == SEQ_W'(SEQ_MAX - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r <= in_data;
            if (in_bad) begin
              rsp_r   <= '{status: ST_RANGE, default: '0};
              state_r <= S_FIN;
            end else begin
              rsp_r   <= '0;
              state_r <= in_data.op ? S_Q_A : S_M_A;
            end
          end
        end
        S_Q_A: begin
          rsp_r.root_of_seq <= em_rdata.label;
          if (otu_ok(em_rdata.otu)) begin
            rsp_r.otu_of_seq <= em_rdata.otu[SEQ_W-1:0];
            rsp_r.otu_valid  <= 1'b1;
            state_r          <= S_Q_L;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_Q_L: begin
          rsp_r.otu_similarity <= lv_rdata;
          state_r              <= S_FIN;
        end
        S_M_A: begin
          lab_a_r <= em_rdata.label;
          otu_a_r <= em_rdata.otu;
          state_r <= S_M_B;
        end
        S_M_B: begin
          x_r <= lo_root;
          y_r <= hi_root;
          // order the linked sequences' OTUs by their roots
          otu_dx_r <= (lab_a_r > em_rdata.label) ? em_rdata.otu : otu_a_r;
          otu_dy_r <= (lab_a_r > em_rdata.label) ? otu_a_r : em_rdata.otu;
          set_x_r  <= 1'b0;
          set_y_r  <= 1'b0;
          rsp_r.kept_root     <= lo_root;
          rsp_r.absorbed_root <= hi_root;
          if (lab_a_r == em_rdata.label) begin
            rsp_r.status <= ST_SAME;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_M_X;
          end
        end
        S_M_X: begin
          size_x_r <= em_rdata.size;
          otu_x_r  <= em_rdata.otu;
          state_r  <= S_M_Y;
        end
        S_M_Y: begin
          size_y_r <= em_rdata.size;
          otu_y_r  <= em_rdata.otu;
          state_r  <= S_M_DEC;
        end
        S_M_DEC: begin
          if (big) begin
            tgt_x_r <= cnt_r;
            set_x_r <= new_x;
            if (new_x) cnt_r <= cnt_r + 1'b1;
            state_r <= S_M_NEW;
          end else begin
            state_r <= S_M_JY;
          end
        end
        S_M_NEW: begin
          tgt_y_r   <= cnt_r;
          set_y_r   <= new_y;
          if (new_y) cnt_r <= cnt_r + 1'b1;
          scan_rd_r <= '0;
          state_r   <= S_SCAN;
        end
        S_M_JY: begin
          tgt_y_r  <= id_y;
          set_y_r  <= app_y;
          eff_dy_r <= eff_dy;
          eff_y_r  <= eff_y;
          state_r  <= S_M_JX;
        end
        S_M_JX: begin
          tgt_x_r   <= id_x;
          set_x_r   <= app_x;
          scan_rd_r <= '0;
          state_r   <= S_SCAN;
        end
        S_SCAN: begin
          // read one entry a cycle, write it back the cycle after
          wb_v_r <= em_re;
          if (em_re) begin
            wb_addr_r <= scan_rd_r[SEQ_W-1:0];
            scan_rd_r <= scan_rd_r + 1'b1;
          end
          if (wb_v_r && wb_addr_r == SEQ_W'(SEQ_MAX - 1)) begin
            rsp_r.status <= ST_DONE;
            state_r      <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register frees
          if (!out_valid_r || out_ready) begin
            out_r       <= fin_rsp;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OTU_W'(SEQ_MAX))
    else $error("OTU count beyond id space");

  a_scan_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && $past(state_r) == S_SCAN) |-> $stable(cnt_r))
    else $error("OTU count moved during sweep");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request accepted during clearing pass");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded");

endmodule
